@@ rtl/fpf_pkg.sv @@
package fpf_pkg;

    // Plane storage and job sizing.
    localparam int MAX_PLANES = 8;
    localparam int PLANE_W    = 16;
    localparam int JOB_BYTES  = 2 * MAX_PLANES;
    localparam int JOB_W      = 8 * JOB_BYTES;
    localparam int CNT_W      = $clog2(JOB_BYTES + 1);
    localparam int PLN_CNT_W  = $clog2(MAX_PLANES + 1);

    // Register widths and indexes.
    localparam int BPP_W  = 6;
    localparam int MODE_W = 3;
    localparam int CFG_W  = 6;
    localparam logic REG_BPP  = 1'b0;
    localparam logic REG_MODE = 1'b1;

    // Output format codes.
    localparam logic [MODE_W-1:0] MODE_PLANAR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CHUNK1 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHUNK2 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHUNK3 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CHUNK4 = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PACKED = 3'd5;

    // Direct-color depths and the reset depth.
    localparam logic [BPP_W-1:0] BPP_RGB565 = 6'd16;
    localparam logic [BPP_W-1:0] BPP_RGB24  = 6'd24;
    localparam logic [BPP_W-1:0] BPP_ARGB   = 6'd32;
    localparam logic [BPP_W-1:0] BPP_RESET  = 6'd8;

    // One burst of bytes for the back end, first byte in the top bits.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [JOB_W-1:0] data;
    } job_t;

    // Queue status seen by the front end.
    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    // Back end status: pop request and bytes still pending.
    typedef struct packed {
        logic pop;
        logic pending;
    } back_status_t;

    // Indices that fit in one byte for a packed depth of 1 to 8.
    function automatic logic [3:0] packed_per(input logic [3:0] bpp);
        logic [3:0] per;
        case (bpp)
            4'd1:    per = 4'd8;
            4'd2:    per = 4'd4;
            4'd3:    per = 4'd2;
            4'd4:    per = 4'd2;
            default: per = 4'd1;
        endcase
        return per;
    endfunction

endpackage

@@ rtl/framebuffer_pixel_formatter_unit.sv @@
// Framebuffer pixel formatter.
// Input channel: one pixel per beat (palette_index, red, green, blue, alpha),
// taken when in_valid is high and in_stall is low.
// Output channel: one framebuffer byte per beat (out_byte, last), taken when
// out_valid is high and out_stall is low; last marks a burst's final byte.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 depth,
// 1 format); write only while the block is idle.
// Throughput: one output byte per cycle while out_stall is low, sent by
// the back end serializer (four bytes per ARGB pixel in four-byte chunk
// formats, two per plane per 16-pixel planar group); pixels that produce
// nothing are taken one per cycle while the queue is not full. A pixel's
// burst passes through the queue and burst shifter to the output register.
// A two-beat burst queue sits between the front end and the serializer.
// Reset clears the gather state, sets depth 8 and planar format.
// When the receiver stalls, the output beat holds, the queue fills and
// in_stall rises once both queue entries are occupied.
module framebuffer_pixel_formatter_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [fpf_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                palette_index,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    input  logic [7:0]                alpha,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                out_byte,
    output logic                      last
);
    import fpf_pkg::*;

    logic          q_push;
    job_t          q_job_in;
    job_t          q_job_out;
    queue_status_t q_status;
    back_status_t  b_status;

    fpf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .palette_index (palette_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_job         (q_job_in)
    );

    fpf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (q_job_in),
        .pop     (b_status.pop),
        .job_out (q_job_out),
        .status  (q_status)
    );

    fpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_job     (q_job_out),
        .q_status  (q_status),
        .status    (b_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

`ifndef NO_ASSERTIONS
    // A burst is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("burst pushed into full queue");

    // The serializer never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        b_status.pop |-> q_status.valid)
        else $error("pop from empty queue");

    // Queued bursts always carry at least one byte.
    a_nonempty_job: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_job_in.count != '0))
        else $error("empty burst queued");

    // After a byte that is not the last of its burst, more bytes are pending.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |-> b_status.pending)
        else $error("burst ended without last");
`endif

endmodule

@@ rtl/fpf_front.sv @@
module fpf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [fpf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    palette_index,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    alpha,
    input  fpf_pkg::queue_status_t        q_status,
    output logic                          q_push,
    output fpf_pkg::job_t                 q_job
);
    import fpf_pkg::*;

    logic [BPP_W-1:0]   bpp_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [PLANE_W-1:0] words_reg [MAX_PLANES];
    logic [PLANE_W-1:0] words_next [MAX_PLANES];
    logic [PLANE_W-1:0] words_new [MAX_PLANES];
    logic [3:0]         group_reg;
    logic [3:0]         group_next;
    logic [7:0]         pacc_reg;
    logic [7:0]         pacc_next;
    logic [2:0]         pcnt_reg;
    logic [2:0]         pcnt_next;

    logic               accept;
    logic [PLN_CNT_W-1:0] planes;
    logic [31:0]        chunk;
    logic               chunk_ok;
    logic [2:0]         chunk_bytes;
    logic [2:0]         chunk_start;
    logic               skip_top;
    logic [31:0]        chunk_aligned;
    logic [7:0]         pmask;
    logic [15:0]        pshift;
    logic [7:0]         pacc_new;
    job_t               job;

    // The front takes a pixel whenever the queue has room.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept && (job.count != '0);
    assign q_job    = job;

    // Plane count saturates at the number of stored planes.
    assign planes = (bpp_reg > BPP_W'(MAX_PLANES)) ? PLN_CNT_W'(MAX_PLANES)
                                                    : PLN_CNT_W'(bpp_reg);

    // Planar gather: set this pixel's bit in each active plane.
    always_comb
    begin
        for (int j = 0; j < MAX_PLANES; j++)
        begin
            if (PLN_CNT_W'(j) < planes)
                words_new[j] = words_reg[j]
                    | (PLANE_W'(palette_index[j]) << (4'd15 - group_reg));
            else
                words_new[j] = words_reg[j];
        end
    end

    // Chunk value by depth.
    always_comb
    begin
        chunk    = '0;
        chunk_ok = 1'b1;
        case (bpp_reg) inside
            6'd1, 6'd2, 6'd4, 6'd6, 6'd8:
                chunk = {24'b0, palette_index};
            BPP_RGB565:
                chunk = {16'b0, red[7:3], green[7:2], blue[7:3]};
            BPP_RGB24, BPP_ARGB:
                chunk = {alpha, red, green, blue};
            default:
                chunk_ok = 1'b0;
        endcase
    end

    // Chunk width and alignment so that the first byte sent sits on top.
    assign chunk_bytes   = (mode_reg == MODE_CHUNK1) ? 3'd1 :
                           (mode_reg == MODE_CHUNK2) ? 3'd2 : 3'd4;
    assign skip_top      = (bpp_reg == BPP_RGB24);
    assign chunk_start   = 3'd4 - chunk_bytes + {2'b0, skip_top};
    assign chunk_aligned = chunk << {chunk_start, 3'b0};

    // Packed accumulation.
    assign pmask    = 8'((9'd1 << bpp_reg[3:0]) - 9'd1);
    assign pshift   = {8'b0, pacc_reg} << bpp_reg[3:0];
    assign pacc_new = pshift[7:0] | (palette_index & pmask);

    // Classify the pixel: build its byte burst and the next state.
    always_comb
    begin
        job        = '0;
        words_next = words_reg;
        group_next = group_reg;
        pacc_next  = pacc_reg;
        pcnt_next  = pcnt_reg;
        case (mode_reg) inside
            MODE_PLANAR:
            begin
                if (group_reg == 4'd15)
                begin
                    for (int j = 0; j < MAX_PLANES; j++)
                    begin
                        job.data[JOB_W-1-PLANE_W*j -: PLANE_W] = words_new[j];
                        words_next[j] = '0;
                    end
                    job.count  = CNT_W'({planes, 1'b0});
                    group_next = '0;
                end
                else
                begin
                    words_next = words_new;
                    group_next = group_reg + 4'd1;
                end
            end
            MODE_CHUNK1, MODE_CHUNK2, MODE_CHUNK3, MODE_CHUNK4:
            begin
                if (chunk_ok)
                begin
                    job.data[JOB_W-1 -: 32] = chunk_aligned;
                    job.count = CNT_W'(chunk_bytes) - CNT_W'(skip_top);
                end
            end
            MODE_PACKED:
            begin
                if (bpp_reg != '0 && bpp_reg <= BPP_W'(8))
                begin
                    if ({1'b0, pcnt_reg} + 4'd1 >= packed_per(bpp_reg[3:0]))
                    begin
                        job.data[JOB_W-1 -: 8] = pacc_new;
                        job.count = CNT_W'(1);
                        pacc_next = '0;
                        pcnt_next = '0;
                    end
                    else
                    begin
                        pacc_next = pacc_new;
                        pcnt_next = pcnt_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                job = '0;
            end
        endcase
    end

    // Configuration and gather state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= BPP_RESET;
            mode_reg  <= MODE_PLANAR;
            group_reg <= '0;
            pacc_reg  <= '0;
            pcnt_reg  <= '0;
            for (int j = 0; j < MAX_PLANES; j++)
                words_reg[j] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BPP)
                    bpp_reg <= cfg_data[BPP_W-1:0];
                else
                    mode_reg <= cfg_data[MODE_W-1:0];
            end
            if (accept)
            begin
                words_reg <= words_next;
                group_reg <= group_next;
                pacc_reg  <= pacc_next;
                pcnt_reg  <= pcnt_next;
            end
        end
    end

endmodule

@@ rtl/fpf_queue.sv @@
module fpf_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  fpf_pkg::job_t          job_in,
    input  logic                   pop,
    output fpf_pkg::job_t          job_out,
    output fpf_pkg::queue_status_t status
);
    import fpf_pkg::*;

    job_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign job_out      = entries_reg[rd_ptr_reg];
    assign status.valid = (fill_reg != 2'd0);
    assign status.full  = (fill_reg == 2'd2);

    // Occupancy tracks pushes and pops in the same cycle.
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= job_in;
    end

endmodule

@@ rtl/fpf_back.sv @@
module fpf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpf_pkg::job_t         q_job,
    input  fpf_pkg::queue_status_t q_status,
    output fpf_pkg::back_status_t status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  last
);
    import fpf_pkg::*;

    logic [JOB_W-1:0] data_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             advance;
    logic             pop;

    // A byte moves into the output register when it is empty or drained.
    assign advance = (cnt_reg != '0) && (!valid_reg || !out_stall);
    // The next burst loads when no burst is pending or as the current one sends its final byte.
    assign pop = q_status.valid
                 && ((cnt_reg == '0) || (advance && cnt_reg == CNT_W'(1)));

    assign status.pop     = pop;
    assign status.pending = (cnt_reg != '0);
    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign last           = last_reg;

    // Burst counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                cnt_reg <= q_job.count;
            else if (advance)
                cnt_reg <= cnt_reg - CNT_W'(1);
            if (advance)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    // Burst shifter and output beat.
    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= q_job.data;
        else if (advance)
            data_reg <= {data_reg[JOB_W-9:0], 8'b0};
        if (advance)
        begin
            byte_reg <= data_reg[JOB_W-1 -: 8];
            last_reg <= (cnt_reg == CNT_W'(1));
        end
    end

endmodule
